/* rtl/core/owtr_pkg.sv */
package owtr_pkg;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_RST_LOW,
        PH_RST_WAIT,
        PH_RST_TAIL,
        PH_WR_LOW,
        PH_WR_HOLD,
        PH_RD_LOW,
        PH_RD_WAIT,
        PH_RD_TAIL
    } t_phase;

    localparam logic [3:0] STEP_RST_FIRST   = 4'd0;
    localparam logic [3:0] STEP_SKIP_FIRST  = 4'd1;
    localparam logic [3:0] STEP_CONVERT     = 4'd2;
    localparam logic [3:0] STEP_POLL        = 4'd3;
    localparam logic [3:0] STEP_RST_SECOND  = 4'd4;
    localparam logic [3:0] STEP_SKIP_SECOND = 4'd5;
    localparam logic [3:0] STEP_READ_CMD    = 4'd6;
    localparam logic [3:0] STEP_RD_LO       = 4'd7;
    localparam logic [3:0] STEP_RD_HI       = 4'd8;
    localparam logic [3:0] STEP_RST_LAST    = 4'd9;
    localparam logic [3:0] STEP_END         = 4'd10;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRATCH = 8'hBE;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TAIL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_SAMPLE   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_TAIL     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_POLL_LIMIT    = 3'd7;

    localparam logic [9:0]  RST_RESET_LOW     = 10'd430;
    localparam logic [7:0]  RST_PRESENCE_WAIT = 8'd60;
    localparam logic [9:0]  RST_RESET_TAIL    = 10'd420;
    localparam logic [3:0]  RST_SLOT_LOW      = 4'd1;
    localparam logic [7:0]  RST_WRITE_HOLD    = 8'd50;
    localparam logic [5:0]  RST_READ_SAMPLE   = 6'd10;
    localparam logic [7:0]  RST_READ_TAIL     = 8'd40;
    localparam logic [15:0] RST_POLL_LIMIT    = 16'd20000;

    typedef struct packed {
        logic [9:0]  reset_low;
        logic [7:0]  presence_wait;
        logic [9:0]  reset_tail;
        logic [3:0]  slot_low;
        logic [7:0]  write_hold;
        logic [5:0]  read_sample;
        logic [7:0]  read_tail;
        logic [15:0] poll_limit;
    } t_cfg;

    typedef struct packed {
        logic        drive_low;
        logic        busy;
        logic        done;
        logic        no_presence;
        logic        timed_out;
        logic [10:0] tenths;
        logic [15:0] raw;
    } t_res;

    function automatic logic [7:0] step_cmd(input logic [3:0] step);
        logic [7:0] cmd;
        case (step)
            STEP_SKIP_FIRST:  cmd = CMD_SKIP_ROM;
            STEP_CONVERT:     cmd = CMD_CONVERT;
            STEP_SKIP_SECOND: cmd = CMD_SKIP_ROM;
            STEP_READ_CMD:    cmd = CMD_READ_SCRATCH;
            default:          cmd = 8'h00;
        endcase
        return cmd;
    endfunction

    // sixteenths of a degree to whole tenths, rounded down
    function automatic logic [3:0] frac_tenths(input logic [3:0] nib);
        logic [3:0] t;
        case (nib)
            4'd0, 4'd1:   t = 4'd0;
            4'd2, 4'd3:   t = 4'd1;
            4'd4:         t = 4'd2;
            4'd5, 4'd6:   t = 4'd3;
            4'd7:         t = 4'd4;
            4'd8, 4'd9:   t = 4'd5;
            4'd10, 4'd11: t = 4'd6;
            4'd12:        t = 4'd7;
            4'd13, 4'd14: t = 4'd8;
            default:      t = 4'd9;
        endcase
        return t;
    endfunction

endpackage

/* rtl/core/owtr_conv.sv */
module owtr_conv (
    input  logic [7:0]  i_scratch_low,
    input  logic [7:0]  i_scratch_high,
    output logic [10:0] o_tenths
);

    logic [6:0]  digit;
    logic [10:0] digit_x10;

    assign digit     = {i_scratch_high[2:0], i_scratch_low[7:4]};
    assign digit_x10 = {1'b0, digit, 3'b000} + {3'b000, digit, 1'b0};
    assign o_tenths  = digit_x10 + {7'd0, owtr_pkg::frac_tenths(i_scratch_low[3:0])};

endmodule

/* rtl/core/owtr_seq.sv */
module owtr_seq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic              i_start_req,
    input  logic              i_line_in,
    input  owtr_pkg::t_cfg    i_cfg,
    output owtr_pkg::t_res    o_res
);

    owtr_pkg::t_phase r_phase, n_phase, cur_phase;
    logic [9:0]  r_tick, n_tick, tick_inc, dur;
    logic [2:0]  r_bit, n_bit;
    logic [3:0]  r_step, n_step, step_inc;
    logic [7:0]  r_shift, n_shift;
    logic [7:0]  r_lo, n_lo;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_poll, n_poll;
    logic        r_pres, n_pres;
    logic        r_tmo, n_tmo;
    logic [10:0] r_result, n_result;
    logic        n_done, adv, start_now;
    logic        drive, busy;
    logic [10:0] conv_tenths;

    owtr_conv u_conv (
        .i_scratch_low  (r_lo),
        .i_scratch_high (r_hi),
        .o_tenths       (conv_tenths)
    );

    assign start_now = (r_phase == owtr_pkg::PH_IDLE) && i_start_req;
    assign cur_phase = start_now ? owtr_pkg::PH_RST_LOW : r_phase;

    always_comb begin
        n_phase  = r_phase;
        n_tick   = r_tick;
        n_bit    = r_bit;
        n_step   = r_step;
        n_shift  = r_shift;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_poll   = r_poll;
        n_pres   = r_pres;
        n_tmo    = r_tmo;
        n_result = r_result;
        n_done   = 1'b0;
        adv      = 1'b0;
        dur      = '0;
        step_inc = '0;

        if (start_now) begin
            n_pres   = 1'b0;
            n_tmo    = 1'b0;
            n_lo     = '0;
            n_hi     = '0;
            n_poll   = '0;
            n_result = '0;
            n_step   = owtr_pkg::STEP_RST_FIRST;
            n_tick   = '0;
            n_bit    = '0;
        end
        n_phase = cur_phase;

        unique case (cur_phase)
            owtr_pkg::PH_RST_LOW:  dur = i_cfg.reset_low;
            owtr_pkg::PH_RST_WAIT: dur = {2'b00, i_cfg.presence_wait};
            owtr_pkg::PH_RST_TAIL: dur = i_cfg.reset_tail;
            owtr_pkg::PH_WR_LOW,
            owtr_pkg::PH_RD_LOW:   dur = {6'd0, i_cfg.slot_low};
            owtr_pkg::PH_WR_HOLD:  dur = {2'b00, i_cfg.write_hold};
            owtr_pkg::PH_RD_WAIT:  dur = {4'd0, i_cfg.read_sample};
            owtr_pkg::PH_RD_TAIL:  dur = {2'b00, i_cfg.read_tail};
            default:               dur = '0;
        endcase

        tick_inc = n_tick + 10'd1;

        if (cur_phase != owtr_pkg::PH_IDLE) begin
            n_tick = tick_inc;
            if (tick_inc >= dur || tick_inc == '0) begin
                n_tick = '0;
                unique case (cur_phase)
                    owtr_pkg::PH_RST_LOW: n_phase = owtr_pkg::PH_RST_WAIT;
                    owtr_pkg::PH_RST_WAIT: begin
                        if (i_line_in) n_pres = 1'b1;
                        n_phase = owtr_pkg::PH_RST_TAIL;
                    end
                    owtr_pkg::PH_RST_TAIL: adv = 1'b1;
                    owtr_pkg::PH_WR_LOW: n_phase = owtr_pkg::PH_WR_HOLD;
                    owtr_pkg::PH_WR_HOLD: begin
                        if (n_bit == 3'd7) begin
                            adv = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = owtr_pkg::PH_WR_LOW;
                        end
                    end
                    owtr_pkg::PH_RD_LOW: n_phase = owtr_pkg::PH_RD_WAIT;
                    owtr_pkg::PH_RD_WAIT: begin
                        n_shift = {i_line_in, n_shift[7:1]};
                        n_phase = owtr_pkg::PH_RD_TAIL;
                    end
                    owtr_pkg::PH_RD_TAIL: begin
                        if (n_step == owtr_pkg::STEP_POLL) begin
                            if (n_shift[7]) begin
                                adv = 1'b1;
                            end else begin
                                n_poll = n_poll + 16'd1;
                                if (n_poll >= i_cfg.poll_limit || n_poll == '0) begin
                                    n_tmo   = 1'b1;
                                    n_phase = owtr_pkg::PH_IDLE;
                                    n_done  = 1'b1;
                                end else begin
                                    n_shift = '0;
                                    n_phase = owtr_pkg::PH_RD_LOW;
                                end
                            end
                        end else if (n_bit == 3'd7) begin
                            if (n_step == owtr_pkg::STEP_RD_LO) n_lo = n_shift;
                            else n_hi = n_shift;
                            adv = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = owtr_pkg::PH_RD_LOW;
                        end
                    end
                    default: n_phase = cur_phase;
                endcase
            end
        end

        if (adv) begin
            step_inc = n_step + 4'd1;
            n_step   = step_inc;
            n_tick   = '0;
            n_bit    = '0;
            if (step_inc >= owtr_pkg::STEP_END) begin
                n_result = conv_tenths;
                n_phase  = owtr_pkg::PH_IDLE;
                n_done   = 1'b1;
            end else if (step_inc == owtr_pkg::STEP_RST_SECOND ||
                         step_inc == owtr_pkg::STEP_RST_LAST) begin
                n_phase = owtr_pkg::PH_RST_LOW;
            end else if (step_inc == owtr_pkg::STEP_POLL ||
                         step_inc == owtr_pkg::STEP_RD_LO ||
                         step_inc == owtr_pkg::STEP_RD_HI) begin
                n_shift = '0;
                n_phase = owtr_pkg::PH_RD_LOW;
            end else begin
                n_shift = owtr_pkg::step_cmd(step_inc);
                n_phase = owtr_pkg::PH_WR_LOW;
            end
        end
    end

    always_comb begin
        busy  = 1'b1;
        drive = 1'b0;
        unique case (cur_phase)
            owtr_pkg::PH_IDLE:    busy  = 1'b0;
            owtr_pkg::PH_RST_LOW,
            owtr_pkg::PH_WR_LOW,
            owtr_pkg::PH_RD_LOW:  drive = 1'b1;
            owtr_pkg::PH_WR_HOLD: drive = ~r_shift[r_bit];
            default:              drive = 1'b0;
        endcase
    end

    assign o_res.drive_low   = drive;
    assign o_res.busy        = busy;
    assign o_res.done        = n_done;
    assign o_res.no_presence = n_pres;
    assign o_res.timed_out   = n_tmo;
    assign o_res.tenths      = n_result;
    assign o_res.raw         = {n_hi, n_lo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= owtr_pkg::PH_IDLE;
            r_tick   <= '0;
            r_bit    <= '0;
            r_step   <= '0;
            r_shift  <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_poll   <= '0;
            r_pres   <= 1'b0;
            r_tmo    <= 1'b0;
            r_result <= '0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_tick   <= n_tick;
            r_bit    <= n_bit;
            r_step   <= n_step;
            r_shift  <= n_shift;
            r_lo     <= n_lo;
            r_hi     <= n_hi;
            r_poll   <= n_poll;
            r_pres   <= n_pres;
            r_tmo    <= n_tmo;
            r_result <= n_result;
        end
    end

endmodule

/* rtl/core/one_wire_temperature_reader.sv */
// Channel   Direction  Handshake                   Payload
// input     in         i_in_valid / o_in_stall     i_start_req, i_line_in
// result    out        o_out_valid / i_out_stall   o_drive_low .. o_raw_reading
// config    in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
// One item per cycle while the input is not stalled: the sequencer state advances and
// the result register loads at the same edge, so each item's result is visible in the cycle after acceptance.
// Reset (synchronous) returns the sequencer to idle and the timing registers to
// their defaults. A stalled result register stalls the input channel.
module one_wire_temperature_reader (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_start_req,
    input  logic                              i_line_in,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_drive_low,
    output logic                              o_busy_res,
    output logic                              o_done_res,
    output logic                              o_no_presence,
    output logic                              o_timed_out,
    output logic [10:0]                       o_temperature_tenths,
    output logic [15:0]                       o_raw_reading,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    owtr_pkg::t_cfg r_cfg;
    owtr_pkg::t_res seq_res;
    logic           in_accept;
    logic           r_out_valid;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign in_accept   = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reset_low     <= owtr_pkg::RST_RESET_LOW;
            r_cfg.presence_wait <= owtr_pkg::RST_PRESENCE_WAIT;
            r_cfg.reset_tail    <= owtr_pkg::RST_RESET_TAIL;
            r_cfg.slot_low      <= owtr_pkg::RST_SLOT_LOW;
            r_cfg.write_hold    <= owtr_pkg::RST_WRITE_HOLD;
            r_cfg.read_sample   <= owtr_pkg::RST_READ_SAMPLE;
            r_cfg.read_tail     <= owtr_pkg::RST_READ_TAIL;
            r_cfg.poll_limit    <= owtr_pkg::RST_POLL_LIMIT;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                owtr_pkg::CFG_RESET_LOW:     r_cfg.reset_low     <= i_cfg_data[9:0];
                owtr_pkg::CFG_PRESENCE_WAIT: r_cfg.presence_wait <= i_cfg_data[7:0];
                owtr_pkg::CFG_RESET_TAIL:    r_cfg.reset_tail    <= i_cfg_data[9:0];
                owtr_pkg::CFG_SLOT_LOW:      r_cfg.slot_low      <= i_cfg_data[3:0];
                owtr_pkg::CFG_WRITE_HOLD:    r_cfg.write_hold    <= i_cfg_data[7:0];
                owtr_pkg::CFG_READ_SAMPLE:   r_cfg.read_sample   <= i_cfg_data[5:0];
                owtr_pkg::CFG_READ_TAIL:     r_cfg.read_tail     <= i_cfg_data[7:0];
                default:                     r_cfg.poll_limit    <= i_cfg_data;
            endcase
        end
    end

    owtr_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_advance   (in_accept),
        .i_start_req (i_start_req),
        .i_line_in   (i_line_in),
        .i_cfg       (r_cfg),
        .o_res       (seq_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            o_drive_low          <= seq_res.drive_low;
            o_busy_res           <= seq_res.busy;
            o_done_res           <= seq_res.done;
            o_no_presence        <= seq_res.no_presence;
            o_timed_out          <= seq_res.timed_out;
            o_temperature_tenths <= seq_res.tenths;
            o_raw_reading        <= seq_res.raw;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

/* tb/tb_one_wire_temperature_reader.sv */
`timescale 1ns / 1ps

module tb_one_wire_temperature_reader;
    import owtr_pkg::*;

    localparam int CYCLE_LIMIT   = 100_000;
    localparam int ITEMS_TARGET  = 1100;
    localparam int N_ROWS        = 7;
    localparam int MAX_PRINTED   = 50;

    localparam int SET_MAX  = 0;
    localparam int SET_ZERO = 1;
    localparam int SET_ONE  = 2;
    localparam int SET_CALM = 3;

    typedef struct packed {
        logic        present;
        logic [7:0]  busy_polls;
        logic [15:0] word;
        logic        typed;
        logic        exp_np;
        logic        exp_to;
        logic [10:0] exp_tenths;
        logic [15:0] exp_raw;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [N_ROWS] = '{
        '{1'b1, 8'd1, 16'h0191, 1'b1, 1'b0, 1'b0, 11'd250,  16'h0191},
        '{1'b1, 8'd0, 16'h07FF, 1'b1, 1'b0, 1'b0, 11'd1279, 16'h07FF},
        '{1'b1, 8'd1, 16'hFFFF, 1'b1, 1'b0, 1'b0, 11'd1279, 16'hFFFF},
        '{1'b1, 8'd0, 16'hFC98, 1'b1, 1'b0, 1'b0, 11'd735,  16'hFC98},
        '{1'b0, 8'd2, 16'h0550, 1'b1, 1'b1, 1'b0, 11'd850,  16'h0550},
        '{1'b1, 8'd3, 16'h1234, 1'b1, 1'b0, 1'b1, 11'd0,    16'h0000},
        '{1'b0, 8'd5, 16'h4321, 1'b1, 1'b1, 1'b1, 11'd0,    16'h0000}
    };

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_start_req = 1'b0;
    logic        i_line_in   = 1'b1;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic        o_drive_low;
    logic        o_busy_res;
    logic        o_done_res;
    logic        o_no_presence;
    logic        o_timed_out;
    logic [10:0] o_temperature_tenths;
    logic [15:0] o_raw_reading;
    logic        o_cfg_ready;

    one_wire_temperature_reader dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_start_req          (i_start_req),
        .i_line_in            (i_line_in),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_drive_low          (o_drive_low),
        .o_busy_res           (o_busy_res),
        .o_done_res           (o_done_res),
        .o_no_presence        (o_no_presence),
        .o_timed_out          (o_timed_out),
        .o_temperature_tenths (o_temperature_tenths),
        .o_raw_reading        (o_raw_reading),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_index          (i_cfg_index),
        .i_cfg_data           (i_cfg_data)
    );

    // bus master mirror
    t_phase      ph;
    logic [9:0]  tick_cnt;
    logic [2:0]  bit_cnt;
    logic [3:0]  step_no;
    logic [7:0]  shreg;
    logic [7:0]  byte_lo;
    logic [7:0]  byte_hi;
    logic [15:0] poll_cnt;
    logic        no_pres;
    logic        gave_up;
    logic        done_now;
    logic [10:0] tenths;
    t_cfg        tim;

    // emulated sensor
    bit          dev_present;
    int          dev_polls;
    logic [15:0] dev_word;
    bit          dev_noisy;

    t_res        expected_items [$];
    t_dir_row    typed_dones [$];
    logic [15:0] reg_plan [8];
    bit          calm = 1'b0;
    int          mismatches = 0;
    int          ticks_fed = 0;
    int          reads_done = 0;
    int          reads_timed_out = 0;
    int          reads_no_presence = 0;
    int          settings_used = 0;
    int unsigned cycle_cnt = 0;

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) cycle_cnt <= cycle_cnt + 1;

    function automatic logic [7:0] command_of(input logic [3:0] s);
        case (s)
            STEP_SKIP_FIRST, STEP_SKIP_SECOND: return CMD_SKIP_ROM;
            STEP_CONVERT:                      return CMD_CONVERT;
            STEP_READ_CMD:                     return CMD_READ_SCRATCH;
            default:                           return 8'h00;
        endcase
    endfunction

    function automatic logic [9:0] span_of(input t_phase which);
        case (which)
            PH_RST_LOW:           return tim.reset_low;
            PH_RST_WAIT:          return {2'b00, tim.presence_wait};
            PH_RST_TAIL:          return tim.reset_tail;
            PH_WR_LOW, PH_RD_LOW: return {6'd0, tim.slot_low};
            PH_WR_HOLD:           return {2'b00, tim.write_hold};
            PH_RD_WAIT:           return {4'd0, tim.read_sample};
            default:              return {2'b00, tim.read_tail};
        endcase
    endfunction

    function automatic void latch_temperature();
        logic [6:0] whole;
        int         frac;
        whole = {byte_hi[2:0], byte_lo[7:4]};
        frac = (byte_lo[3:0] * 625) / 1000;
        tenths = 11'(whole * 10 + frac);
        ph = PH_IDLE;
        done_now = 1'b1;
    endfunction

    function automatic void open_step(input logic [3:0] s);
        step_no = s;
        tick_cnt = '0;
        bit_cnt = '0;
        if (step_no >= STEP_END) begin
            latch_temperature();
        end else if (step_no == STEP_RST_FIRST || step_no == STEP_RST_SECOND
                     || step_no == STEP_RST_LAST) begin
            ph = PH_RST_LOW;
        end else if (step_no == STEP_POLL || step_no == STEP_RD_LO || step_no == STEP_RD_HI) begin
            shreg = '0;
            ph = PH_RD_LOW;
        end else begin
            shreg = command_of(step_no);
            ph = PH_WR_LOW;
        end
    endfunction

    function automatic void close_phase(input logic line);
        tick_cnt = '0;
        case (ph)
            PH_RST_LOW: ph = PH_RST_WAIT;
            PH_RST_WAIT: begin
                if (line) no_pres = 1'b1;
                ph = PH_RST_TAIL;
            end
            PH_RST_TAIL: open_step(step_no + 4'd1);
            PH_WR_LOW: ph = PH_WR_HOLD;
            PH_WR_HOLD: begin
                if (bit_cnt == 3'd7) begin
                    open_step(step_no + 4'd1);
                end else begin
                    bit_cnt = bit_cnt + 3'd1;
                    ph = PH_WR_LOW;
                end
            end
            PH_RD_LOW: ph = PH_RD_WAIT;
            PH_RD_WAIT: begin
                shreg = {line, shreg[7:1]};
                ph = PH_RD_TAIL;
            end
            default: begin
                if (step_no == STEP_POLL) begin
                    if (shreg[7]) begin
                        open_step(step_no + 4'd1);
                    end else begin
                        poll_cnt = poll_cnt + 16'd1;
                        if (poll_cnt >= tim.poll_limit || poll_cnt == 16'd0) begin
                            gave_up = 1'b1;
                            ph = PH_IDLE;
                            done_now = 1'b1;
                        end else begin
                            shreg = '0;
                            ph = PH_RD_LOW;
                        end
                    end
                end else if (bit_cnt == 3'd7) begin
                    if (step_no == STEP_RD_LO) byte_lo = shreg;
                    else byte_hi = shreg;
                    open_step(step_no + 4'd1);
                end else begin
                    bit_cnt = bit_cnt + 3'd1;
                    ph = PH_RD_LOW;
                end
            end
        endcase
    endfunction

    function automatic t_res next_bus_outputs(input logic start, input logic line);
        t_res       r;
        logic [9:0] span;
        r = '0;
        done_now = 1'b0;
        if (ph == PH_IDLE && start) begin
            no_pres = 1'b0;
            gave_up = 1'b0;
            byte_lo = '0;
            byte_hi = '0;
            poll_cnt = '0;
            tenths = '0;
            open_step(STEP_RST_FIRST);
        end
        if (ph != PH_IDLE) begin
            r.busy = 1'b1;
            if (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW) r.drive_low = 1'b1;
            else if (ph == PH_WR_HOLD) r.drive_low = !shreg[bit_cnt];
            span = span_of(ph);
            tick_cnt = tick_cnt + 10'd1;
            if (tick_cnt >= span || tick_cnt == 10'd0) close_phase(line);
        end
        r.done = done_now;
        r.no_presence = no_pres;
        r.timed_out = gave_up;
        r.tenths = tenths;
        r.raw = {byte_hi, byte_lo};
        return r;
    endfunction

    function automatic logic bus_level();
        if (dev_noisy) return 1'($urandom_range(0, 1));
        case (ph)
            PH_RST_WAIT: return !dev_present;
            PH_RD_WAIT: begin
                if (step_no == STEP_POLL) return poll_cnt >= dev_polls;
                else if (step_no == STEP_RD_HI) return dev_word[8 + bit_cnt];
                else return dev_word[bit_cnt];
            end
            PH_RST_LOW, PH_WR_LOW, PH_RD_LOW: return 1'b0;
            PH_WR_HOLD: return shreg[bit_cnt];
            default: return 1'b1;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatches < MAX_PRINTED)
            $display("%0t error: %s got %0d, want %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic feed_tick(input logic start, input logic line);
        t_res want;
        while (!calm && $urandom_range(0, 99) < 30) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_start_req <= start;
        i_line_in <= line;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        want = next_bus_outputs(start, line);
        expected_items.push_back(want);
        ticks_fed++;
        if (want.done) begin
            reads_done++;
            if (want.timed_out) reads_timed_out++;
            if (want.no_presence) reads_no_presence++;
        end
        @(negedge i_clk);
    endtask

    task automatic run_read(input bit present, input int busy_polls, input logic [15:0] word,
                            input bit noisy);
        dev_present = present;
        dev_polls = busy_polls;
        dev_word = word;
        dev_noisy = noisy;
        repeat ($urandom_range(0, 3)) feed_tick(1'b0, 1'($urandom_range(0, 1)));
        feed_tick(1'b1, 1'($urandom_range(0, 1)));
        // stray start requests mid-read must be ignored
        while (ph != PH_IDLE) feed_tick($urandom_range(0, 9) == 0, bus_level());
    endtask

    task automatic program_regs();
        int k;
        i_in_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        for (k = 0; k < 8; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= k[2:0];
            i_cfg_data <= reg_plan[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (k[2:0])
                CFG_RESET_LOW:     tim.reset_low     = reg_plan[k][9:0];
                CFG_PRESENCE_WAIT: tim.presence_wait = reg_plan[k][7:0];
                CFG_RESET_TAIL:    tim.reset_tail    = reg_plan[k][9:0];
                CFG_SLOT_LOW:      tim.slot_low      = reg_plan[k][3:0];
                CFG_WRITE_HOLD:    tim.write_hold    = reg_plan[k][7:0];
                CFG_READ_SAMPLE:   tim.read_sample   = reg_plan[k][5:0];
                CFG_READ_TAIL:     tim.read_tail     = reg_plan[k][7:0];
                default:           tim.poll_limit    = reg_plan[k];
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
        settings_used++;
    endtask

    always @(negedge i_clk) i_out_stall <= !calm && ($urandom_range(0, 99) < 30);

    always @(posedge i_clk) begin : result_check
        t_res     want;
        t_dir_row row;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_items.size() == 0) begin
                report_mismatch("result with nothing pending, done", o_done_res, 0);
            end else begin
                want = expected_items.pop_front();
                if (o_drive_low !== want.drive_low)
                    report_mismatch("drive_low", o_drive_low, want.drive_low);
                if (o_busy_res !== want.busy)
                    report_mismatch("busy_res", o_busy_res, want.busy);
                if (o_done_res !== want.done)
                    report_mismatch("done_res", o_done_res, want.done);
                if (o_no_presence !== want.no_presence)
                    report_mismatch("no_presence", o_no_presence, want.no_presence);
                if (o_timed_out !== want.timed_out)
                    report_mismatch("timed_out", o_timed_out, want.timed_out);
                if (o_temperature_tenths !== want.tenths)
                    report_mismatch("temperature_tenths", o_temperature_tenths, want.tenths);
                if (o_raw_reading !== want.raw)
                    report_mismatch("raw_reading", o_raw_reading, want.raw);
            end
            if (o_done_res && typed_dones.size() != 0) begin
                row = typed_dones.pop_front();
                if (row.typed) begin
                    if (o_no_presence !== row.exp_np)
                        report_mismatch("directed no_presence", o_no_presence, row.exp_np);
                    if (o_timed_out !== row.exp_to)
                        report_mismatch("directed timed_out", o_timed_out, row.exp_to);
                    if (o_temperature_tenths !== row.exp_tenths)
                        report_mismatch("directed tenths", o_temperature_tenths, row.exp_tenths);
                    if (o_raw_reading !== row.exp_raw)
                        report_mismatch("directed raw_reading", o_raw_reading, row.exp_raw);
                end
            end
        end
    end

    initial begin : watchdog
        while (cycle_cnt < CYCLE_LIMIT) @(posedge i_clk);
        $display("run stopped at the cycle limit with %0d results pending",
                 expected_items.size());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int          r;
        int          k;
        int          p;
        logic [15:0] spare;
        ph = PH_IDLE;
        tick_cnt = '0;
        bit_cnt = '0;
        step_no = '0;
        shreg = '0;
        byte_lo = '0;
        byte_hi = '0;
        poll_cnt = '0;
        no_pres = 1'b0;
        gave_up = 1'b0;
        done_now = 1'b0;
        tenths = '0;
        tim = '{RST_RESET_LOW, RST_PRESENCE_WAIT, RST_RESET_TAIL, RST_SLOT_LOW,
                RST_WRITE_HOLD, RST_READ_SAMPLE, RST_READ_TAIL, RST_POLL_LIMIT};
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // short timings, poll limit of three slots
        reg_plan = '{16'd1, 16'd2, 16'd1, 16'd1, 16'd1, 16'd1, 16'd1, 16'd3};
        program_regs();
        for (r = 0; r < N_ROWS; r++) begin
            typed_dones.push_back(DIR_ROWS[r]);
            run_read(DIR_ROWS[r].present, DIR_ROWS[r].busy_polls, DIR_ROWS[r].word, 1'b0);
        end

        p = 0;
        while (p <= SET_CALM || ticks_fed < ITEMS_TARGET) begin
            for (k = 0; k < 8; k++) begin
                case (k[2:0])
                    CFG_RESET_LOW, CFG_RESET_TAIL: spare = 16'hFC00;
                    CFG_SLOT_LOW:                  spare = 16'hFFF0;
                    CFG_READ_SAMPLE:               spare = 16'hFFC0;
                    CFG_POLL_LIMIT:                spare = 16'h0000;
                    default:                       spare = 16'hFF00;
                endcase
                case (p)
                    // widest poll limit, junk above every narrower register
                    SET_MAX:  reg_plan[k] = (k == CFG_POLL_LIMIT) ? 16'hFFFF
                                                                  : (spare | 16'h0001);
                    SET_ZERO: reg_plan[k] = 16'h0000;
                    SET_ONE:  reg_plan[k] = 16'h0001;
                    default: begin
                        if (k == CFG_POLL_LIMIT) reg_plan[k] = 16'($urandom_range(0, 6));
                        else reg_plan[k] = 16'($urandom_range(0, 2));
                        // junk above the register width must be dropped
                        if ($urandom_range(0, 3) == 0)
                            reg_plan[k] = reg_plan[k] | (spare & 16'($urandom));
                    end
                endcase
            end
            program_regs();
            calm = (p == SET_CALM);
            run_read($urandom_range(0, 99) < 85, $urandom_range(0, (p == SET_MAX) ? 2 : 4),
                     16'($urandom), $urandom_range(0, 99) < 15);
            calm = 1'b0;
            p++;
        end

        i_in_valid <= 1'b0;
        while (expected_items.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        $display("%0d bus ticks, %0d temperature reads under %0d timing settings",
                 ticks_fed, reads_done, settings_used);
        $display("%0d reads gave up polling, %0d saw no presence pulse",
                 reads_timed_out, reads_no_presence);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
